[design/sst_pkg.sv]
// Shared types, constants and helpers for the scored sighting table.
`timescale 1ns / 1ps
`default_nettype none

package sst_pkg;

  localparam int unsigned TABLE_ENTRIES = 32;
  localparam int unsigned IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int unsigned CNT_W         = $clog2(TABLE_ENTRIES + 1);

  localparam int unsigned OP_W     = 2;
  localparam int unsigned ADDR_W   = 48;
  localparam int unsigned TYPE_W   = 2;
  localparam int unsigned RSSI_W   = 8;
  localparam int unsigned COUNT_W  = 16;
  localparam int unsigned READ_W   = 5;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned SLOT_W   = 5;
  localparam int unsigned HELD_W   = 6;
  localparam int unsigned SCORE_W  = 3;
  localparam int unsigned CMP_W    = (CNT_W > READ_W) ? CNT_W : READ_W;

  localparam logic [COUNT_W-1:0] COUNT_MAX   = '1;
  localparam logic [SCORE_W-1:0] SCORE_DFU   = 3'd4;
  localparam logic [SCORE_W-1:0] SCORE_NAMED = 3'd2;

  typedef enum logic [OP_W-1:0] {
    OP_SIGHT = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_UPDATED  = 3'd0,
    ST_INSERTED = 3'd1,
    ST_REPLACED = 3'd2,
    ST_DROPPED  = 3'd3,
    ST_READ_OK  = 3'd4,
    ST_EMPTY    = 3'd5,
    ST_CLEARED  = 3'd6
  } status_e;

  typedef enum logic [3:0] {
    CS_IDLE,
    CS_DISP,
    CS_HIT_RD,
    CS_HIT_CHK,
    CS_MISS,
    CS_EVI_RD,
    CS_EVI_CHK,
    CS_EVI_DEC,
    CS_READ_DAT,
    CS_DONE
  } state_e;

  typedef struct packed {
    logic [ADDR_W-1:0]        addr;
    logic [TYPE_W-1:0]        atype;
    logic signed [RSSI_W-1:0] last_rssi;
    logic signed [RSSI_W-1:0] best_rssi;
    logic [COUNT_W-1:0]       count;
    logic                     named;
    logic                     dfu;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic in_ready;
    logic rd_en;
    logic rd_ridx;
    logic idx_clr;
    logic idx_inc;
    logic hit_write;
    logic insert;
    logic evi_update;
    logic replace;
    logic drop;
    logic read_load;
    logic read_empty;
    logic clear;
    logic push;
  } cmd_t;

  typedef struct packed {
    logic in_valid;
    op_e  op;
    logic fill_zero;
    logic full;
    logic match;
    logic last_hit;
    logic last_evi;
    logic better;
    logic read_ok;
    logic out_free;
  } sts_t;

  function automatic logic [SCORE_W-1:0] score_of(input logic named, input logic dfu);
    logic [SCORE_W-1:0] s;
    s = '0;
    if (dfu) s = s + SCORE_DFU;
    if (named) s = s + SCORE_NAMED;
    return s;
  endfunction

endpackage

`default_nettype wire

[design/sst_in_if.sv]
// Input channel of the scored sighting table.
`timescale 1ns / 1ps
`default_nettype none

interface sst_in_if import sst_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          op;
  logic [ADDR_W-1:0]        peer_addr;
  logic [TYPE_W-1:0]        peer_addr_type;
  logic signed [RSSI_W-1:0] signal_strength;
  logic                     named;
  logic                     dfu_seen;
  logic [READ_W-1:0]        read_index;

  modport source (
    output valid, op, peer_addr, peer_addr_type, signal_strength, named, dfu_seen,
           read_index,
    input  ready
  );

  modport sink (
    input  valid, op, peer_addr, peer_addr_type, signal_strength, named, dfu_seen,
           read_index,
    output ready
  );
endinterface

`default_nettype wire

[design/sst_out_if.sv]
// Result channel of the scored sighting table.
`timescale 1ns / 1ps
`default_nettype none

interface sst_out_if import sst_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [STATUS_W-1:0]      status;
  logic [SLOT_W-1:0]        slot;
  logic [ADDR_W-1:0]        entry_addr;
  logic [TYPE_W-1:0]        entry_addr_type;
  logic signed [RSSI_W-1:0] entry_last_rssi;
  logic signed [RSSI_W-1:0] entry_best_rssi;
  logic [COUNT_W-1:0]       entry_count;
  logic                     entry_named;
  logic                     entry_dfu;
  logic [HELD_W-1:0]        held;

  modport source (
    output valid, status, slot, entry_addr, entry_addr_type, entry_last_rssi,
           entry_best_rssi, entry_count, entry_named, entry_dfu, held,
    input  ready
  );

  modport sink (
    input  valid, status, slot, entry_addr, entry_addr_type, entry_last_rssi,
           entry_best_rssi, entry_count, entry_named, entry_dfu, held,
    output ready
  );
endinterface

`default_nettype wire

[design/sst_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module sst_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[design/sst_datapath.sv]
// Datapath: item register, table RAM, scan and victim registers, result registers.
`timescale 1ns / 1ps
`default_nettype none

module sst_datapath import sst_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  sst_in_if.sink            in_i,
  sst_out_if.source         out_o,
  input  cmd_t              cmd_i,
  output sts_t              sts_o
);

  // held item
  op_e                      op_q;
  logic [ADDR_W-1:0]        addr_q;
  logic [TYPE_W-1:0]        atype_q;
  logic signed [RSSI_W-1:0] rssi_q;
  logic                     named_q;
  logic                     dfu_q;
  logic [READ_W-1:0]        ridx_q;

  logic [IDX_W-1:0]         idx_q, idx_d;
  logic [CNT_W-1:0]         fill_q, fill_d;
  logic [IDX_W-1:0]         worst_idx_q;
  logic [SCORE_W-1:0]       worst_score_q;
  logic signed [RSSI_W-1:0] worst_rssi_q;

  status_e                  res_status_q;
  logic [SLOT_W-1:0]        res_slot_q;
  entry_t                   res_entry_q;

  logic                     out_valid_q;
  status_e                  out_status_q;
  logic [SLOT_W-1:0]        out_slot_q;
  entry_t                   out_entry_q;
  logic [HELD_W-1:0]        out_held_q;

  logic                     accept;
  entry_t                   rdata;
  entry_t                   wdata;
  entry_t                   upd_entry;
  entry_t                   new_entry;
  logic                     we;
  logic [IDX_W-1:0]         waddr;
  logic [IDX_W-1:0]         raddr;
  logic [IDX_W-1:0]         ridx_addr;
  logic [SCORE_W-1:0]       rd_score;
  logic [SCORE_W-1:0]       item_score;
  logic                     evi_take;

  assign accept    = in_i.valid && cmd_i.in_ready;
  assign in_i.ready = cmd_i.in_ready;

  assign ridx_addr = IDX_W'(CMP_W'(ridx_q));
  assign raddr     = cmd_i.rd_ridx ? ridx_addr : idx_q;

  always_comb begin
    new_entry           = '0;
    new_entry.addr      = addr_q;
    new_entry.atype     = atype_q;
    new_entry.last_rssi = rssi_q;
    new_entry.best_rssi = rssi_q;
    new_entry.count     = COUNT_W'(1);
    new_entry.named     = named_q;
    new_entry.dfu       = dfu_q;
  end

  always_comb begin
    upd_entry           = rdata;
    upd_entry.last_rssi = rssi_q;
    if (rssi_q > rdata.best_rssi) begin
      upd_entry.best_rssi = rssi_q;
    end
    if (rdata.count != COUNT_MAX) begin
      upd_entry.count = rdata.count + COUNT_W'(1);
    end
    upd_entry.named = rdata.named | named_q;
    upd_entry.dfu   = rdata.dfu | dfu_q;
  end

  assign we    = cmd_i.hit_write || cmd_i.insert || cmd_i.replace;
  assign wdata = cmd_i.hit_write ? upd_entry : new_entry;

  always_comb begin
    waddr = idx_q;
    if (cmd_i.insert) begin
      waddr = IDX_W'(fill_q);
    end else if (cmd_i.replace) begin
      waddr = worst_idx_q;
    end
  end

  sst_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(TABLE_ENTRIES)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (cmd_i.rd_en),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign rd_score   = score_of(rdata.named, rdata.dfu);
  assign item_score = score_of(named_q, dfu_q);
  assign evi_take   = (idx_q == '0) || (rd_score < worst_score_q) ||
                      ((rd_score == worst_score_q) && (rdata.last_rssi < worst_rssi_q));

  always_comb begin
    sts_o.in_valid  = in_i.valid;
    sts_o.op        = op_q;
    sts_o.fill_zero = (fill_q == '0);
    sts_o.full      = (fill_q == CNT_W'(TABLE_ENTRIES));
    sts_o.match     = (rdata.addr == addr_q) && (rdata.atype == atype_q);
    sts_o.last_hit  = ((CNT_W'(idx_q) + CNT_W'(1)) == fill_q);
    sts_o.last_evi  = (idx_q == IDX_W'(TABLE_ENTRIES - 1));
    sts_o.better    = (item_score > worst_score_q) ||
                      ((item_score == worst_score_q) && (rssi_q > worst_rssi_q));
    sts_o.read_ok   = (CMP_W'(ridx_q) < CMP_W'(fill_q));
    sts_o.out_free  = !out_valid_q || out_o.ready;
  end

  always_comb begin
    idx_d = idx_q;
    if (accept || cmd_i.idx_clr) begin
      idx_d = '0;
    end else if (cmd_i.idx_inc) begin
      idx_d = idx_q + IDX_W'(1);
    end
  end

  always_comb begin
    fill_d = fill_q;
    if (cmd_i.clear) begin
      fill_d = '0;
    end else if (cmd_i.insert) begin
      fill_d = fill_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q  <= idx_d;
      fill_q <= fill_d;
      if (cmd_i.push) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q    <= op_e'(in_i.op);
      addr_q  <= in_i.peer_addr;
      atype_q <= in_i.peer_addr_type;
      rssi_q  <= in_i.signal_strength;
      named_q <= in_i.named;
      dfu_q   <= in_i.dfu_seen;
      ridx_q  <= in_i.read_index;
    end
    if (cmd_i.evi_update && evi_take) begin
      worst_idx_q   <= idx_q;
      worst_score_q <= rd_score;
      worst_rssi_q  <= rdata.last_rssi;
    end
    if (cmd_i.hit_write) begin
      res_status_q <= ST_UPDATED;
      res_slot_q   <= SLOT_W'(idx_q);
      res_entry_q  <= '0;
    end
    if (cmd_i.insert) begin
      res_status_q <= ST_INSERTED;
      res_slot_q   <= SLOT_W'(fill_q);
      res_entry_q  <= '0;
    end
    if (cmd_i.replace) begin
      res_status_q <= ST_REPLACED;
      res_slot_q   <= SLOT_W'(worst_idx_q);
      res_entry_q  <= '0;
    end
    if (cmd_i.drop) begin
      res_status_q <= ST_DROPPED;
      res_slot_q   <= '0;
      res_entry_q  <= '0;
    end
    if (cmd_i.read_load) begin
      res_status_q <= ST_READ_OK;
      res_slot_q   <= SLOT_W'(ridx_q);
      res_entry_q  <= rdata;
    end
    if (cmd_i.read_empty) begin
      res_status_q <= ST_EMPTY;
      res_slot_q   <= SLOT_W'(ridx_q);
      res_entry_q  <= '0;
    end
    if (cmd_i.clear) begin
      res_status_q <= ST_CLEARED;
      res_slot_q   <= '0;
      res_entry_q  <= '0;
    end
    if (cmd_i.push) begin
      out_status_q <= res_status_q;
      out_slot_q   <= res_slot_q;
      out_entry_q  <= res_entry_q;
      out_held_q   <= HELD_W'(fill_q);
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.status          = out_status_q;
  assign out_o.slot            = out_slot_q;
  assign out_o.entry_addr      = out_entry_q.addr;
  assign out_o.entry_addr_type = out_entry_q.atype;
  assign out_o.entry_last_rssi = out_entry_q.last_rssi;
  assign out_o.entry_best_rssi = out_entry_q.best_rssi;
  assign out_o.entry_count     = out_entry_q.count;
  assign out_o.entry_named     = out_entry_q.named;
  assign out_o.entry_dfu       = out_entry_q.dfu;
  assign out_o.held            = out_held_q;

endmodule

`default_nettype wire

[design/sst_ctrl.sv]
// Controller: sequences lookup, insertion, victim scan, reads and clears.
`timescale 1ns / 1ps
`default_nettype none

module sst_ctrl import sst_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CS_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      CS_IDLE: begin
        if (sts_i.in_valid) state_d = CS_DISP;
      end
      CS_DISP: begin
        unique case (sts_i.op)
          OP_SIGHT: state_d = sts_i.fill_zero ? CS_MISS : CS_HIT_RD;
          OP_READ:  state_d = sts_i.read_ok ? CS_READ_DAT : CS_DONE;
          OP_CLEAR: state_d = CS_DONE;
          default:  state_d = CS_IDLE;
        endcase
      end
      CS_HIT_RD: state_d = CS_HIT_CHK;
      CS_HIT_CHK: begin
        if (sts_i.match) begin
          state_d = CS_DONE;
        end else if (sts_i.last_hit) begin
          state_d = CS_MISS;
        end else begin
          state_d = CS_HIT_RD;
        end
      end
      CS_MISS: state_d = sts_i.full ? CS_EVI_RD : CS_DONE;
      CS_EVI_RD: state_d = CS_EVI_CHK;
      CS_EVI_CHK: state_d = sts_i.last_evi ? CS_EVI_DEC : CS_EVI_RD;
      CS_EVI_DEC: state_d = CS_DONE;
      CS_READ_DAT: state_d = CS_DONE;
      CS_DONE: begin
        if (sts_i.out_free) state_d = CS_IDLE;
      end
      default: state_d = CS_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      CS_IDLE: cmd_o.in_ready = 1'b1;
      CS_DISP: begin
        unique case (sts_i.op)
          OP_READ: begin
            cmd_o.rd_en      = sts_i.read_ok;
            cmd_o.rd_ridx    = 1'b1;
            cmd_o.read_empty = !sts_i.read_ok;
          end
          OP_CLEAR: cmd_o.clear = 1'b1;
          default: ;
        endcase
      end
      CS_HIT_RD: cmd_o.rd_en = 1'b1;
      CS_HIT_CHK: begin
        cmd_o.hit_write = sts_i.match;
        cmd_o.idx_inc   = !sts_i.match && !sts_i.last_hit;
      end
      CS_MISS: begin
        cmd_o.idx_clr = sts_i.full;
        cmd_o.insert  = !sts_i.full;
      end
      CS_EVI_RD: cmd_o.rd_en = 1'b1;
      CS_EVI_CHK: begin
        cmd_o.evi_update = 1'b1;
        cmd_o.idx_inc    = !sts_i.last_evi;
      end
      CS_EVI_DEC: begin
        cmd_o.replace = sts_i.better;
        cmd_o.drop    = !sts_i.better;
      end
      CS_READ_DAT: cmd_o.read_load = 1'b1;
      CS_DONE: cmd_o.push = sts_i.out_free;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

[design/scored_sighting_table_top.sv]
// Top level of the scored sighting table.
//
// One word is taken at a time; in_i.ready is high only while the block waits
// for work, and a finished result may still sit in the output register while
// the next word is taken. A result that finds the output register still full
// holds the block until that register drains. The table is one RAM with one
// write port and one registered read port, walked one entry at a time, each
// entry read in its read state and checked in its check state. On a miss
// with the table full a victim walk over every entry follows. Clear drops
// the fill count only, so no clearing pass follows reset or clear.
`timescale 1ns / 1ps
`default_nettype none

module scored_sighting_table_top import sst_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  sst_in_if.sink    in_i,
  sst_out_if.source out_o
);

  cmd_t cmd;
  sts_t sts;

  sst_ctrl u_ctrl (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .sts_i (sts),
    .cmd_o (cmd)
  );

  sst_datapath u_dp (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_i),
    .out_o (out_o),
    .cmd_i (cmd),
    .sts_o (sts)
  );

endmodule

`default_nettype wire

[design/sst_checker.sv]
// Port-level assertions for the scored sighting table, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module sst_checker import sst_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_i,
  input logic                out_valid_i,
  input logic                out_ready_i,
  input logic [STATUS_W-1:0] status_i,
  input logic [SLOT_W-1:0]   slot_i,
  input logic [HELD_W-1:0]   held_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(status_i) && $stable(slot_i))
    else $error("result word changed while stalled");

  a_one_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("second word taken while busy");

  a_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (status_i == ST_CLEARED) |-> (held_i == '0) && (slot_i == '0))
    else $error("clear left entries held");

  a_dropped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (status_i == ST_DROPPED) |->
      (held_i == HELD_W'(TABLE_ENTRIES)) && (slot_i == '0))
    else $error("drop with table not full");

endmodule

bind scored_sighting_table_top sst_checker u_sst_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_i.valid),
  .in_ready_i (in_i.ready),
  .out_valid_i(out_o.valid),
  .out_ready_i(out_o.ready),
  .status_i   (out_o.status),
  .slot_i     (out_o.slot),
  .held_i     (out_o.held)
);

`default_nettype wire
